FILE: rtl/core/byte_ring_buffer_overwrite_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the byte ring buffer.
// The including module must have clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_BUFFER_OVERWRITE_MACROS_SVH
`define BYTE_RING_BUFFER_OVERWRITE_MACROS_SVH

// Condition that must hold at every clock edge out of reset
`define BRBO_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge
`define BRBO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/brbo_pkg.sv
// ----------------------------------------------------------------------------
// brbo_pkg
// Types and constants shared by the byte ring buffer files.
// ----------------------------------------------------------------------------
package brbo_pkg;

    // Buffer depth and derived widths
    localparam int DEPTH = 256;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OFF_W = (CNT_W > 9) ? CNT_W : 9;
    localparam int SUM_W = OFF_W + 1;

    // Operation codes
    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_READ  = 2'd2,
        MODE_CLEAR = 2'd3
    } brbo_mode_t;

    // Command word
    typedef struct packed {
        brbo_mode_t  mode;
        logic [7:0]  push_byte;
        logic [8:0]  pop_count;
        logic [7:0]  read_offset;
    } brbo_cmd_t;

    // Result word
    typedef struct packed {
        logic [7:0]  read_byte;
        logic        accepted;
        logic [8:0]  removed;
        logic [8:0]  fill_level;
        logic [8:0]  room_left;
    } brbo_rsp_t;

endpackage

FILE: rtl/core/brbo_ram.sv
// ----------------------------------------------------------------------------
// brbo_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module brbo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/byte_ring_buffer_overwrite.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_overwrite
// Byte ring buffer with push, pop, indexed read and clear; a push onto a
// full buffer either drops the oldest byte or is rejected (keep_oldest).
//
//   channel   signals                 handshake
//   command   cmd (brbo_cmd_t)        start && !busy
//   result    rsp (brbo_rsp_t)        done, one cycle, no backpressure
//   config    cfg_wdata (keep_oldest) cfg_we
//
// One command word per cycle; its result word follows in the cycle after
// acceptance, from the result registers and the registered read port of the byte store.
// busy is never raised, so commands may be issued back to back.
// rst_n clears pointer, fill count, keep_oldest and the result strobe; the
// byte store keeps no reset and needs no clearing pass.
// The receiver cannot stall: each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
`include "byte_ring_buffer_overwrite_macros.svh"

module byte_ring_buffer_overwrite
    import brbo_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  brbo_cmd_t cmd,
    output logic      done,
    output brbo_rsp_t rsp,
    input  logic      cfg_we,
    input  logic      cfg_wdata
);

    // Ring index arithmetic: base + off, wrapped once (off never reaches DEPTH
    // where the result is used)
    function automatic logic [PTR_W-1:0] wrap(input logic [PTR_W-1:0] base,
                                              input logic [OFF_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    logic             accept;
    logic [PTR_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] held_reg, held_next;
    logic             keep_oldest_reg;
    logic             valid_reg;
    logic             hit_reg, hit_next;
    logic             accepted_reg, accepted_next;
    logic [8:0]       removed_reg, removed_next;
    logic [8:0]       fill_reg, room_reg;
    logic [OFF_W-1:0] held_w, pop_w, fill_w, room_w;
    logic             full;
    logic             ram_we, ram_re;
    logic [PTR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]       ram_rdata;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign held_w = OFF_W'(held_reg);
    assign pop_w  = OFF_W'(cmd.pop_count);
    assign full   = (held_reg >= CNT_W'(DEPTH));

    // Command decode and next state
    always_comb
    begin
        front_next    = front_reg;
        held_next     = held_reg;
        hit_next      = 1'b0;
        accepted_next = 1'b0;
        removed_next  = 9'd0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_waddr     = wrap(front_reg, held_w);
        ram_raddr     = wrap(front_reg, OFF_W'(cmd.read_offset));
        unique case (cmd.mode)
            MODE_PUSH:
            begin
                if (!(full && keep_oldest_reg))
                begin
                    accepted_next = 1'b1;
                    ram_we        = accept;
                    if (full)
                    begin
                        // drop oldest: new byte lands where the oldest was
                        ram_waddr  = front_reg;
                        front_next = wrap(front_reg, OFF_W'(1));
                    end
                    else
                    begin
                        held_next = held_reg + CNT_W'(1);
                    end
                end
            end
            MODE_POP:
            begin
                if (held_reg != '0)
                begin
                    if (pop_w >= held_w)
                    begin
                        removed_next = held_w[8:0];
                        held_next    = '0;
                        front_next   = '0;
                    end
                    else
                    begin
                        removed_next = cmd.pop_count;
                        front_next   = wrap(front_reg, pop_w);
                        held_next    = held_reg - CNT_W'(cmd.pop_count);
                    end
                end
            end
            MODE_READ:
            begin
                hit_next = (OFF_W'(cmd.read_offset) < held_w);
                ram_re   = accept;
            end
            MODE_CLEAR:
            begin
                held_next     = '0;
                front_next    = '0;
                accepted_next = 1'b1;
            end
        endcase
    end

    // Counts as reported, masked to the field width
    assign fill_w = OFF_W'(held_next);
    assign room_w = OFF_W'(DEPTH) - fill_w;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg       <= '0;
            held_reg        <= '0;
            keep_oldest_reg <= 1'b0;
            valid_reg       <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
            if (cfg_we)
            begin
                keep_oldest_reg <= cfg_wdata;
            end
            if (accept)
            begin
                front_reg <= front_next;
                held_reg  <= held_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg      <= hit_next;
            accepted_reg <= accepted_next;
            removed_reg  <= removed_next;
            fill_reg     <= fill_w[8:0];
            room_reg     <= room_w[8:0];
        end
    end

    // Byte store
    brbo_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd.push_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result word
    assign done           = valid_reg;
    assign rsp.read_byte  = hit_reg ? ram_rdata : 8'd0;
    assign rsp.accepted   = accepted_reg;
    assign rsp.removed    = removed_reg;
    assign rsp.fill_level = fill_reg;
    assign rsp.room_left  = room_reg;

    // Checks
    `BRBO_ASSERT(a_held_in_range, held_reg <= CNT_W'(DEPTH), "fill count above depth")
    `BRBO_ASSERT(a_front_in_range, SUM_W'(front_reg) < SUM_W'(DEPTH), "front index out of range")
    `BRBO_ASSERT_NEXT(a_word_done, start && !busy, done, "accepted word gave no result")
    `BRBO_ASSERT_NEXT(a_no_spurious, !(start && !busy), !done, "result without command word")
    `BRBO_ASSERT_NEXT(a_clear_resets, start && !busy && cmd.mode == MODE_CLEAR, held_reg == '0 && front_reg == '0, "clear left data behind")

endmodule

FILE: test/ring_buffer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring_buffer_checker
// Passive checker for the byte ring buffer. It watches the command, result
// and keep_oldest ports and keeps a shadow copy of the buffer contents,
// front pointer and fill count. It queues one predicted result word per
// accepted command and compares each result word, field by field, against
// the oldest prediction.
// ----------------------------------------------------------------------------
module ring_buffer_checker
    import brbo_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  brbo_cmd_t cmd,
    input  logic      done,
    input  brbo_rsp_t rsp,
    input  logic      cfg_we,
    input  logic      cfg_wdata,
    output int        fail_count,
    output int        pending,
    output int        words_checked,
    output int        full_pushes
);

    // Shadow copy of the buffer
    logic [7:0]  shadow_store [DEPTH];
    int unsigned shadow_front = 0;
    int unsigned shadow_held  = 0;
    logic        shadow_keep  = 1'b0;

    // Result words still owed by the block, oldest first
    brbo_rsp_t   owed_rsp [$];

    int          mismatch_total  = 0;
    int          checked_total   = 0;
    int          full_push_total = 0;

    assign fail_count    = mismatch_total;
    assign words_checked = checked_total;
    assign full_pushes   = full_push_total;

    // One line per mismatch, and count it
    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_total++;
    endtask

    task automatic check_field(input string name, input logic [8:0] got,
                               input logic [8:0] want_v);
        if (got !== want_v)
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want_v));
    endtask

    // Apply one command to the shadow buffer and build its result word
    task automatic step_shadow_buffer(input brbo_cmd_t c, output brbo_rsp_t r);
        r = '0;
        case (c.mode)
            MODE_PUSH:
            begin
                if (shadow_held >= DEPTH)
                    full_push_total++;
                if (!(shadow_held >= DEPTH && shadow_keep))
                begin
                    // overwrite mode: drop the oldest byte first
                    if (shadow_held >= DEPTH)
                    begin
                        shadow_front = (shadow_front + 1) % DEPTH;
                        shadow_held--;
                    end
                    shadow_store[(shadow_front + shadow_held) % DEPTH] = c.push_byte;
                    shadow_held++;
                    r.accepted = 1'b1;
                end
            end
            MODE_POP:
            begin
                if (shadow_held != 0)
                begin
                    if (c.pop_count >= shadow_held)
                    begin
                        r.removed    = 9'(shadow_held);
                        shadow_held  = 0;
                        shadow_front = 0;
                    end
                    else
                    begin
                        r.removed    = c.pop_count;
                        shadow_front = (shadow_front + c.pop_count) % DEPTH;
                        shadow_held  = shadow_held - c.pop_count;
                    end
                end
            end
            MODE_READ:
            begin
                // offsets past the fill level read as zero
                if (c.read_offset < shadow_held)
                    r.read_byte = shadow_store[(shadow_front + c.read_offset) % DEPTH];
            end
            MODE_CLEAR:
            begin
                shadow_held  = 0;
                shadow_front = 0;
                r.accepted   = 1'b1;
            end
        endcase
        r.fill_level = 9'(shadow_held);
        r.room_left  = 9'(DEPTH - shadow_held);
    endtask

    // Predict on accepted commands, compare on result strobes
    always @(posedge clk or negedge rst_n)
    begin
        brbo_rsp_t predicted;
        brbo_rsp_t want;
        if (!rst_n)
        begin
            owed_rsp.delete();
            shadow_front = 0;
            shadow_held  = 0;
            shadow_keep  = 1'b0;
            pending     <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                step_shadow_buffer(cmd, predicted);
                owed_rsp = {owed_rsp, predicted};
            end
            if (done)
            begin
                if (owed_rsp.size() == 0)
                    report_mismatch("result word with no command outstanding");
                else
                begin
                    want = owed_rsp.pop_front();
                    checked_total++;
                    check_field("read_byte", 9'(rsp.read_byte), 9'(want.read_byte));
                    check_field("accepted", 9'(rsp.accepted), 9'(want.accepted));
                    check_field("removed", rsp.removed, want.removed);
                    check_field("fill_level", rsp.fill_level, want.fill_level);
                    check_field("room_left", rsp.room_left, want.room_left);
                end
            end
            // register write takes effect for later commands
            if (cfg_we)
                shadow_keep = cfg_wdata;
            pending <= owed_rsp.size();
        end
    end

endmodule

FILE: test/tb_byte_ring_buffer_overwrite.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_byte_ring_buffer_overwrite
// Stimulus and verdict for the byte ring buffer. A short directed run covers
// empty pops and reads, out-of-range reads, zero and oversized pops and
// clears; random segments then fill the buffer past full in both keep_oldest
// settings and mix all four operations; command gaps vary by segment.
// Checking is done by ring_buffer_checker.
// ----------------------------------------------------------------------------
module tb_byte_ring_buffer_overwrite;
    import brbo_pkg::*;

    typedef enum int { SEG_FILL, SEG_MIXED } seg_kind_t;
    typedef enum int { GAPS_NONE, GAPS_SPARSE, GAPS_HEAVY } gap_style_t;

    localparam int SEG_COUNT = 5;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       start     = 1'b0;
    logic       busy;
    brbo_cmd_t  cmd       = '0;
    logic       done;
    brbo_rsp_t  rsp;
    logic       cfg_we    = 1'b0;
    logic       cfg_wdata = 1'b0;

    int         fail_count;
    int         pending;
    int         words_checked;
    int         full_pushes;
    int         sent_total = 0;
    gap_style_t gap_style  = GAPS_SPARSE;

    always #2 clk = ~clk;

    byte_ring_buffer_overwrite u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    ring_buffer_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .done          (done),
        .rsp           (rsp),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .words_checked (words_checked),
        .full_pushes   (full_pushes)
    );

    // Idle cycles before the next command
    function automatic int draw_gap();
        case (gap_style)
            GAPS_NONE:   return 0;
            GAPS_SPARSE: return ($urandom_range(0, 99) < 80) ? 0 : $urandom_range(1, 16);
            default:     return $urandom_range(0, 16);
        endcase
    endfunction

    function automatic brbo_cmd_t make_word(input brbo_mode_t m, input logic [7:0] b,
                                            input logic [8:0] n, input logic [7:0] off);
        brbo_cmd_t c;
        c.mode        = m;
        c.push_byte   = b;
        c.pop_count   = n;
        c.read_offset = off;
        return c;
    endfunction

    // Random command; unused fields carry random values too
    function automatic brbo_cmd_t random_word(input seg_kind_t kind);
        brbo_cmd_t c;
        int        pick;
        int        sub;
        c.push_byte   = 8'($urandom);
        c.pop_count   = 9'($urandom_range(0, 256));
        c.read_offset = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
        pick = $urandom_range(0, 99);
        sub  = $urandom_range(0, 99);
        if (kind == SEG_FILL)
        begin
            // push-heavy: drives the buffer to full and keeps it there
            if (pick < 90)
                c.mode = MODE_PUSH;
            else if (pick < 96)
                c.mode = MODE_READ;
            else
            begin
                c.mode      = MODE_POP;
                c.pop_count = 9'($urandom_range(0, 3));
            end
        end
        else
        begin
            if (pick < 40)
                c.mode = MODE_PUSH;
            else if (pick < 60)
            begin
                c.mode = MODE_POP;
                if (sub < 60)
                    c.pop_count = 9'($urandom_range(0, 8));
                else if (sub < 85)
                    c.pop_count = 9'($urandom_range(0, 256));
                else
                    c.pop_count = 9'd256;
            end
            else if (pick < 93)
                c.mode = MODE_READ;
            else
                c.mode = MODE_CLEAR;
        end
        return c;
    endfunction

    // Segment schedule: length, keep_oldest, kind
    task automatic seg_plan(input int idx, output int len, output logic keep,
                            output seg_kind_t kind);
        case (idx)
            0:       begin len = 330; keep = 1'b0; kind = SEG_FILL;  end
            1:       begin len = 150; keep = 1'b1; kind = SEG_FILL;  end
            2:       begin len = 150; keep = 1'b0; kind = SEG_MIXED; end
            3:       begin len = 330; keep = 1'b1; kind = SEG_FILL;  end
            default: begin len = 90;  keep = 1'b0; kind = SEG_MIXED; end
        endcase
    endtask

    // Issue one command word and wait for it to be taken
    task automatic issue_word(input brbo_cmd_t c);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        sent_total++;
    endtask

    // Hold off until every owed result word has come back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_keep(input logic value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Main stimulus
    initial
    begin
        int        seg_len;
        logic      seg_keep;
        seg_kind_t seg_kind;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_keep(1'b0);

        // directed: empty buffer, edge bytes, out-of-range reads, pops, clears
        issue_word(make_word(MODE_POP,   8'h00, 9'd5,   8'h00));
        issue_word(make_word(MODE_POP,   8'h00, 9'd0,   8'h00));
        issue_word(make_word(MODE_READ,  8'h00, 9'd0,   8'h00));
        issue_word(make_word(MODE_READ,  8'hFF, 9'd511, 8'hFF));
        issue_word(make_word(MODE_PUSH,  8'h00, 9'd0,   8'h00));
        issue_word(make_word(MODE_PUSH,  8'hFF, 9'd0,   8'h00));
        issue_word(make_word(MODE_PUSH,  8'hA5, 9'd0,   8'h00));
        issue_word(make_word(MODE_PUSH,  8'h5A, 9'd0,   8'h00));
        issue_word(make_word(MODE_READ,  8'h00, 9'd0,   8'h00));
        issue_word(make_word(MODE_READ,  8'h00, 9'd0,   8'h03));
        issue_word(make_word(MODE_READ,  8'h00, 9'd0,   8'h04));
        issue_word(make_word(MODE_POP,   8'h00, 9'd0,   8'h00));
        issue_word(make_word(MODE_POP,   8'h00, 9'd1,   8'h00));
        issue_word(make_word(MODE_READ,  8'h00, 9'd0,   8'h00));
        issue_word(make_word(MODE_POP,   8'h00, 9'd256, 8'h00));
        issue_word(make_word(MODE_PUSH,  8'h3C, 9'd0,   8'h00));
        issue_word(make_word(MODE_PUSH,  8'hC3, 9'd0,   8'h00));
        issue_word(make_word(MODE_CLEAR, 8'hFF, 9'd256, 8'hFF));
        issue_word(make_word(MODE_READ,  8'h00, 9'd0,   8'h00));
        issue_word(make_word(MODE_PUSH,  8'h81, 9'd0,   8'h00));
        issue_word(make_word(MODE_POP,   8'h00, 9'd1,   8'h00));
        issue_word(make_word(MODE_CLEAR, 8'h00, 9'd0,   8'h00));

        // random segments, each starting from an idle block
        for (int s = 0; s < SEG_COUNT; s++)
        begin
            seg_plan(s, seg_len, seg_keep, seg_kind);
            write_keep(seg_keep);
            gap_style = gap_style_t'(s % 3);
            repeat (seg_len) issue_word(random_word(seg_kind));
        end

        drain();
        repeat (4) @(posedge clk);

        $display("Run covered %0d commands and %0d result words under keep_oldest 0 and 1,",
                 sent_total, words_checked);
        $display("including %0d pushes onto a full buffer.", full_pushes);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial
    begin
        #500000;
        $display("Timeout with %0d result words outstanding", pending);
        $display("Test completed with failures");
        $finish;
    end

endmodule
